// File: design/fbtgd_pkg.sv
`timescale 1ns / 1ps
package fbtgd_pkg;

   localparam int TOUCH_SLOTS_DEF = 16;
   localparam int MAX_TAPS_DEF    = 32;

   localparam logic [2:0] OP_DOWN   = 3'd0;
   localparam logic [2:0] OP_UP     = 3'd1;
   localparam logic [2:0] OP_MOTION = 3'd2;
   localparam logic [2:0] OP_CANCEL = 3'd3;
   localparam logic [2:0] OP_FRAME  = 3'd4;

   localparam logic [2:0] CSR_ENABLE        = 3'd0;
   localparam logic [2:0] CSR_BAND_LOW      = 3'd1;
   localparam logic [2:0] CSR_BAND_HIGH     = 3'd2;
   localparam logic [2:0] CSR_PRESS_MS      = 3'd3;
   localparam logic [2:0] CSR_WINDOW_MS     = 3'd4;
   localparam logic [2:0] CSR_WINDOW_END_MS = 3'd5;
   localparam logic [2:0] CSR_CLICK_COUNT   = 3'd6;
   localparam logic [2:0] CSR_SAME_AREA     = 3'd7;

   localparam logic        ENABLE_RST        = 1'b1;
   localparam logic [15:0] BAND_LOW_RST      = 16'd1608;
   localparam logic [15:0] BAND_HIGH_RST     = 16'd1688;
   localparam logic [15:0] PRESS_MS_RST      = 16'd500;
   localparam logic [15:0] WINDOW_MS_RST     = 16'd800;
   localparam logic [15:0] WINDOW_END_MS_RST = 16'd1500;
   localparam logic [5:0]  CLICK_COUNT_RST   = 6'd5;
   localparam logic [15:0] SAME_AREA_RST     = 16'd100;

   localparam logic GESTURE_LONG_PRESS = 1'b0;
   localparam logic GESTURE_FAST_CLICK = 1'b1;

   // slot entry: band_frames, press_start, press_elapsed
   localparam int SLOT_W = 80;

   typedef struct packed {
      logic clear;
      logic load;
      logic clear_cnt;
      logic acc;
   } lane_ctrl_type;

endpackage

// File: design/fold_band_touch_gesture_detect.sv
`timescale 1ns / 1ps
// Folding band touch gesture detector. One transaction is taken at a time.
// Ignored, frame, out-of-range and unmapped events finish in the idle state.
// Up, cancel, motion and out-of-band events pass through slot memory read,
// update and drain; an in-band down adds a tap window check, and a fast click
// evaluation reads one stored tap from the tap memory per cycle with all slot
// lanes compared in parallel. Each result is held in an output register.
// Per-slot state lives in a slot memory with a valid bit per entry, so
// clearing is immediate and no sweep runs.
module fold_band_touch_gesture_detect #(
   parameter int TOUCH_SLOTS = fbtgd_pkg::TOUCH_SLOTS_DEF,
   parameter int MAX_TAPS    = fbtgd_pkg::MAX_TAPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic        req_mapped_ok,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_gesture,
   output logic [3:0]  rsp_touch_slot,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   localparam int SAW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;
   localparam int TAW = $clog2(MAX_TAPS);
   localparam int TCW = $clog2(MAX_TAPS + 1);
   localparam int SW  = fbtgd_pkg::SLOT_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RMW  = 5'b00010,
      ST_TAP  = 5'b00100,
      ST_EVAL = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic        enable_ff;
   logic [15:0] band_low_ff, band_high_ff, press_ms_ff, window_ms_ff;
   logic [15:0] window_end_ms_ff, same_area_ff;
   logic [5:0]  click_count_ff;

   logic [2:0]  op_ff;
   logic [3:0]  slot_ff;
   logic [15:0] pos_x_ff, pos_y_ff;
   logic [31:0] time_ff;

   logic [TOUCH_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [TCW-1:0] tap_count_ff, tap_count_in;
   logic [31:0]    window_start_ff, window_start_in;
   logic [TCW-1:0] idx_ff, idx_in;
   logic           tap_rd_ff, tap_rd_in;
   logic           lp_ff, lp_in;
   logic [TOUCH_SLOTS-1:0] mask_ff, mask_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_gesture_ff, rsp_gesture_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_last_ff, rsp_last_in;

   logic          slot_rd_en, slot_wr_en;
   logic [SW-1:0] slot_rd_data, slot_wr_data;
   logic          tap_wr_en, tap_rd_en;
   logic [15:0]   tap_rd_data;
   logic [TAW-1:0] tap_wr_addr;

   fbtgd_pkg::lane_ctrl_type lane_ctrl;
   logic [TOUCH_SLOTS-1:0]   lane_report;

   logic accept;
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   fbtgd_ram #(.WIDTH(SW), .DEPTH(TOUCH_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_ff[SAW-1:0]),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (req_slot[SAW-1:0]),
      .rd_data (slot_rd_data)
   );

   fbtgd_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_wr_en),
      .wr_addr (tap_wr_addr),
      .wr_data (pos_x_ff),
      .rd_en   (tap_rd_en),
      .rd_addr (idx_ff[TAW-1:0]),
      .rd_data (tap_rd_data)
   );

   fbtgd_match_lanes #(.TOUCH_SLOTS(TOUCH_SLOTS), .MAX_TAPS(MAX_TAPS)) u_lanes (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (lane_ctrl),
      .slot        (slot_ff),
      .pos_x       (pos_x_ff),
      .tap_x       (tap_rd_data),
      .same_area   (same_area_ff),
      .click_count (click_count_ff),
      .report      (lane_report)
   );

   always_comb begin
      logic [15:0] bf;
      logic [31:0] ps, pe;
      logic        in_band, store, tc_nz, out_free;
      logic [31:0] ws;
      logic [32:0] wend, eend, t33;
      logic [3:0]  sel;

      state_in        = state_ff;
      slot_valid_in   = slot_valid_ff;
      tap_count_in    = tap_count_ff;
      window_start_in = window_start_ff;
      idx_in          = idx_ff;
      tap_rd_in       = 1'b0;
      lp_in           = lp_ff;
      mask_in         = mask_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_gesture_in  = rsp_gesture_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_last_in     = rsp_last_ff;
      slot_rd_en      = 1'b0;
      slot_wr_en      = 1'b0;
      slot_wr_data    = '0;
      tap_wr_en       = 1'b0;
      tap_wr_addr     = tap_count_ff[TAW-1:0];
      tap_rd_en       = 1'b0;
      lane_ctrl       = '0;

      in_band  = (pos_y_ff >= band_low_ff) && (pos_y_ff <= band_high_ff);
      bf       = slot_valid_ff[slot_ff[SAW-1:0]] ? slot_rd_data[79:64] : 16'd0;
      ps       = slot_valid_ff[slot_ff[SAW-1:0]] ? slot_rd_data[63:32] : 32'd0;
      pe       = slot_valid_ff[slot_ff[SAW-1:0]] ? slot_rd_data[31:0]  : 32'd0;
      ws       = (tap_count_ff == '0) ? time_ff : window_start_ff;
      wend     = {1'b0, ws} + {17'd0, window_ms_ff};
      eend     = {1'b0, ws} + {17'd0, window_end_ms_ff};
      t33      = {1'b0, time_ff};
      store    = (t33 < wend);
      tc_nz    = (tap_count_ff != '0) || store;
      out_free = !rsp_valid_ff || rsp_ready;
      sel      = '0;
      for (int k = TOUCH_SLOTS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            sel = 4'(k);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && enable_ff && req_op <= fbtgd_pkg::OP_FRAME) begin
               if (!req_mapped_ok) begin
                  slot_valid_in = '0;
                  tap_count_in  = '0;
                  window_start_in = '0;
                  lane_ctrl.clear = 1'b1;
               end else if (req_op != fbtgd_pkg::OP_FRAME &&
                            {1'b0, req_slot} < 5'(TOUCH_SLOTS)) begin
                  slot_rd_en = 1'b1;
                  lp_in      = 1'b0;
                  mask_in    = '0;
                  state_in   = ST_RMW;
               end
            end
         end
         ST_RMW: begin
            slot_wr_en = 1'b1;
            slot_valid_in[slot_ff[SAW-1:0]] = 1'b1;
            if (op_ff == fbtgd_pkg::OP_UP || op_ff == fbtgd_pkg::OP_CANCEL) begin
               bf = '0;
               pe = '0;
               state_in = ST_EMIT;
            end else begin
               bf = in_band ? bf + 1'b1 : 16'd0;
               if (bf == 16'd1) begin
                  ps = time_ff;
                  pe = '0;
               end
               if (bf > 16'd1) begin
                  pe = time_ff - ps;
               end
               if (pe > {16'd0, press_ms_ff}) begin
                  lp_in = 1'b1;
                  bf = '0;
                  pe = '0;
               end
               state_in = (op_ff == fbtgd_pkg::OP_DOWN && in_band) ? ST_TAP : ST_EMIT;
            end
            slot_wr_data = {bf, ps, pe};
         end
         ST_TAP: begin
            window_start_in = ws;
            state_in = ST_EMIT;
            if (store) begin
               lane_ctrl.load = 1'b1;
               if (tap_count_ff != TCW'(MAX_TAPS)) begin
                  tap_wr_en    = 1'b1;
                  tap_count_in = tap_count_ff + 1'b1;
               end
            end
            if (tc_nz && t33 > wend && t33 < eend) begin
               lane_ctrl.clear_cnt = 1'b1;
               idx_in   = '0;
               state_in = ST_EVAL;
            end else if (tc_nz && t33 > eend) begin
               slot_valid_in   = '0;
               tap_count_in    = '0;
               window_start_in = '0;
               lane_ctrl.clear = 1'b1;
            end
         end
         ST_EVAL: begin
            lane_ctrl.acc = tap_rd_ff;
            if (idx_ff < tap_count_ff) begin
               tap_rd_en = 1'b1;
               tap_rd_in = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end else if (!tap_rd_ff) begin
               mask_in         = lane_report;
               slot_valid_in   = '0;
               tap_count_in    = '0;
               window_start_in = '0;
               lane_ctrl.clear = 1'b1;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (lp_ff) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_gesture_in = fbtgd_pkg::GESTURE_LONG_PRESS;
                  rsp_slot_in    = slot_ff;
                  rsp_last_in    = (mask_ff == '0);
                  lp_in          = 1'b0;
               end
            end else if (mask_ff != '0) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_gesture_in = fbtgd_pkg::GESTURE_FAST_CLICK;
                  rsp_slot_in    = sel;
                  mask_in        = mask_ff & (mask_ff - 1'b1);
                  rsp_last_in    = ((mask_ff & (mask_ff - 1'b1)) == '0);
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         slot_valid_ff    <= '0;
         tap_count_ff     <= '0;
         window_start_ff  <= '0;
         idx_ff           <= '0;
         tap_rd_ff        <= 1'b0;
         lp_ff            <= 1'b0;
         mask_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         enable_ff        <= fbtgd_pkg::ENABLE_RST;
         band_low_ff      <= fbtgd_pkg::BAND_LOW_RST;
         band_high_ff     <= fbtgd_pkg::BAND_HIGH_RST;
         press_ms_ff      <= fbtgd_pkg::PRESS_MS_RST;
         window_ms_ff     <= fbtgd_pkg::WINDOW_MS_RST;
         window_end_ms_ff <= fbtgd_pkg::WINDOW_END_MS_RST;
         click_count_ff   <= fbtgd_pkg::CLICK_COUNT_RST;
         same_area_ff     <= fbtgd_pkg::SAME_AREA_RST;
      end else begin
         state_ff        <= state_in;
         slot_valid_ff   <= slot_valid_in;
         tap_count_ff    <= tap_count_in;
         window_start_ff <= window_start_in;
         idx_ff          <= idx_in;
         tap_rd_ff       <= tap_rd_in;
         lp_ff           <= lp_in;
         mask_ff         <= mask_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               fbtgd_pkg::CSR_ENABLE:        enable_ff        <= csr_wr_data[0];
               fbtgd_pkg::CSR_BAND_LOW:      band_low_ff      <= csr_wr_data;
               fbtgd_pkg::CSR_BAND_HIGH:     band_high_ff     <= csr_wr_data;
               fbtgd_pkg::CSR_PRESS_MS:      press_ms_ff      <= csr_wr_data;
               fbtgd_pkg::CSR_WINDOW_MS:     window_ms_ff     <= csr_wr_data;
               fbtgd_pkg::CSR_WINDOW_END_MS: window_end_ms_ff <= csr_wr_data;
               fbtgd_pkg::CSR_CLICK_COUNT:   click_count_ff   <= csr_wr_data[5:0];
               fbtgd_pkg::CSR_SAME_AREA:     same_area_ff     <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         slot_ff  <= req_slot;
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         time_ff  <= req_time_ms;
      end
      rsp_gesture_ff <= rsp_gesture_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gesture    = rsp_gesture_ff;
   assign rsp_touch_slot = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: design/fbtgd_ram.sv
`timescale 1ns / 1ps
module fbtgd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fbtgd_match_lanes.sv
`timescale 1ns / 1ps
module fbtgd_match_lanes #(
   parameter int TOUCH_SLOTS = fbtgd_pkg::TOUCH_SLOTS_DEF,
   parameter int MAX_TAPS    = fbtgd_pkg::MAX_TAPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fbtgd_pkg::lane_ctrl_type  ctrl,
   input  logic [3:0]                slot,
   input  logic [15:0]               pos_x,
   input  logic [15:0]               tap_x,
   input  logic [15:0]               same_area,
   input  logic [5:0]                click_count,
   output logic [TOUCH_SLOTS-1:0]    report
);

   localparam int CW = $clog2(MAX_TAPS + 1);

   logic [15:0]   slot_x_ff [TOUCH_SLOTS];
   logic [TOUCH_SLOTS-1:0] tapped_ff;
   logic [CW-1:0] cnt_ff [TOUCH_SLOTS];
   logic [TOUCH_SLOTS-1:0] hit;

   always_comb begin
      for (int k = 0; k < TOUCH_SLOTS; k++) begin
         logic [15:0] diff;
         diff = (tap_x >= slot_x_ff[k]) ? (tap_x - slot_x_ff[k]) : (slot_x_ff[k] - tap_x);
         hit[k] = (diff <= same_area);
         report[k] = tapped_ff[k] && (cnt_ff[k] != '0) &&
                     (7'(cnt_ff[k]) >= {1'b0, click_count});
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TOUCH_SLOTS; k++) begin
         if (reset || ctrl.clear) begin
            tapped_ff[k] <= 1'b0;
         end else if (ctrl.load && slot == 4'(k)) begin
            tapped_ff[k] <= 1'b1;
         end
         if (reset || ctrl.clear_cnt) begin
            cnt_ff[k] <= '0;
         end else if (ctrl.acc && hit[k]) begin
            cnt_ff[k] <= cnt_ff[k] + 1'b1;
         end
         if (ctrl.load && slot == 4'(k)) begin
            slot_x_ff[k] <= pos_x;
         end
      end
   end

endmodule

// File: design/fbtgd_checker.sv
`timescale 1ns / 1ps
module fbtgd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_gesture,
   input logic [3:0] rsp_touch_slot,
   input logic       rsp_last
);

   // input stays closed while results of a transaction remain
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("input open with results still to come");

   // a result left pending when idle must close its transaction
   assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("idle with non-final result pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gesture) &&
      $stable(rsp_touch_slot) && $stable(rsp_last))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fold_band_touch_gesture_detect fbtgd_checker u_fbtgd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_gesture    (rsp_gesture),
   .rsp_touch_slot (rsp_touch_slot),
   .rsp_last       (rsp_last)
);
